// ===== design/bplar_pkg.sv =====
// Shared types and constants for the button press latch / auto-repeat block.
package bplar_pkg;

    localparam int unsigned BTN_W = 5;
    localparam int unsigned NOW_W = 31;
    localparam int unsigned DL_W  = 32;
    localparam int unsigned CFG_W = 16;

    // op codes
    localparam logic [1:0] OP_EVENT = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_TAKE  = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_FIRST_DELAY = 2'd0;
    localparam logic [1:0] CFG_REPEAT_INTV = 2'd1;
    localparam logic [1:0] CFG_FAST_INTV   = 2'd2;
    localparam logic [1:0] CFG_ACCEL_AFTER = 2'd3;

    localparam logic [CFG_W-1:0] RST_FIRST_DELAY = 16'd350;
    localparam logic [CFG_W-1:0] RST_REPEAT_INTV = 16'd60;
    localparam logic [CFG_W-1:0] RST_FAST_INTV   = 16'd25;
    localparam logic [CFG_W-1:0] RST_ACCEL_AFTER = 16'd1000;

    typedef struct packed {
        logic [1:0]       op;
        logic [BTN_W-1:0] button;
        logic             level;
        logic [NOW_W-1:0] now_ms;
    } t_in;

    typedef struct packed {
        logic fire;
        logic held;
    } t_out;

    typedef struct packed {
        logic             is_down;
        logic             press_latch;
        logic             armed;
        logic [DL_W-1:0]  next_fire_ms;
        logic [NOW_W-1:0] hold_start_ms;
    } t_entry;

    typedef struct packed {
        logic [CFG_W-1:0] first_delay_ms;
        logic [CFG_W-1:0] repeat_interval_ms;
        logic [CFG_W-1:0] fast_interval_ms;
        logic [CFG_W-1:0] accel_after_ms;
    } t_cfg;

endpackage

// ===== design/bplar_mem.sv =====
// Per-button state memory: one write port, one registered read port, valid bits.
module bplar_mem #(
    parameter int unsigned BUTTONS = 17,
    parameter int unsigned IDX_W   = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [IDX_W-1:0]      i_rd_idx,
    output bplar_pkg::t_entry     o_rd_data,
    input  logic                  i_wr_en,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  bplar_pkg::t_entry     i_wr_data
);
    import bplar_pkg::*;

    t_entry               r_mem [BUTTONS];
    logic [BUTTONS-1:0]   r_valid;
    t_entry               r_rd_data;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    // never-written entries read as the reset value (all zero)
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== design/bplar_upd.sv =====
// Entry update logic: applies one item to one button's state.
module bplar_upd (
    input  bplar_pkg::t_in    i_item,
    input  bplar_pkg::t_entry i_entry,
    input  bplar_pkg::t_cfg   i_cfg,
    output bplar_pkg::t_entry o_entry,
    output bplar_pkg::t_out   o_res
);
    import bplar_pkg::*;

    logic [DL_W-1:0] now_x;
    logic [DL_W-1:0] hold;
    logic            fast;
    logic [DL_W-1:0] nf_first;
    logic [DL_W-1:0] nf_rep;
    logic [DL_W-1:0] nf_fast;
    logic            due;
    t_entry          ent;
    logic            fire;

    assign now_x    = {1'b0, i_item.now_ms};
    assign hold     = now_x - {1'b0, i_entry.hold_start_ms};
    // signed hold; negative never counts as long
    assign fast     = !hold[DL_W-1] && (hold[DL_W-2:0] > {15'd0, i_cfg.accel_after_ms});
    assign nf_first = now_x + {16'd0, i_cfg.first_delay_ms};
    assign nf_rep   = now_x + {16'd0, i_cfg.repeat_interval_ms};
    assign nf_fast  = now_x + {16'd0, i_cfg.fast_interval_ms};
    assign due      = now_x >= i_entry.next_fire_ms;

    always_comb begin
        ent  = i_entry;
        fire = 1'b0;
        case (i_item.op)
            OP_EVENT: begin
                if (i_item.level && !i_entry.is_down) begin
                    ent.press_latch = 1'b1;
                end
                ent.is_down = i_item.level;
            end
            OP_QUERY: begin
                if (!i_entry.is_down) begin
                    ent.armed = 1'b0;
                end else if (!i_entry.armed) begin
                    ent.hold_start_ms = i_item.now_ms;
                    ent.next_fire_ms  = nf_first;
                    ent.armed         = 1'b1;
                    ent.press_latch   = 1'b0;
                    fire              = 1'b1;
                end else if (due) begin
                    ent.next_fire_ms = fast ? nf_fast : nf_rep;
                    fire             = 1'b1;
                end
            end
            OP_TAKE: begin
                fire            = i_entry.press_latch;
                ent.press_latch = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_entry  = ent;
    assign o_res.fire = fire;
    assign o_res.held = ent.is_down;

endmodule

// ===== design/button_press_latch_auto_repeat_core.sv =====
// Top level: button press latch and auto-repeat with acceleration.
//
//  channel | signals                          | moves
//  --------+----------------------------------+--------------------------------
//  in      | i_in_valid / o_in_ready / i_in   | op, button, level, now_ms
//  out     | o_out_valid / i_out_ready / o_out| fire, held
//  cfg     | i_cfg_we / i_cfg_idx / i_cfg_data| register write, no handshake
//
// Each transaction is accepted in S_IDLE, where the accept edge launches the
// state memory read; S_EXEC then runs the update and writes the entry back
// together with loading the result register. The single registered memory
// read port sets this order. Reset clears every entry at once via valid bits.
// A result waiting in the output register does not block the next accept;
// only the write-back cycle stalls if the previous result is still untaken.
module button_press_latch_auto_repeat_core #(
    parameter int unsigned BUTTONS = 17
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bplar_pkg::t_in                  i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bplar_pkg::t_out                 o_out,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [bplar_pkg::CFG_W-1:0]     i_cfg_data
);
    import bplar_pkg::*;

    localparam int unsigned IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam logic [BTN_W:0] NUM_BTN = (BTN_W + 1)'(BUTTONS);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state  r_state;
    t_in     r_item;
    logic    r_in_range;
    t_out    r_out;
    logic    r_out_valid;
    t_cfg    r_cfg;

    logic    in_acc;
    logic    in_range;
    logic    out_free;
    logic    done;
    t_entry  rd_entry;
    t_entry  upd_entry;
    t_out    upd_res;

    assign in_range = {1'b0, i_in.button} < NUM_BTN;
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    // write-back only when the result register can take the result
    assign done     = (r_state == S_EXEC) && out_free;

    bplar_mem #(
        .BUTTONS (BUTTONS),
        .IDX_W   (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc && in_range),
        .i_rd_idx  (i_in.button[IDX_W-1:0]),
        .o_rd_data (rd_entry),
        .i_wr_en   (done && r_in_range),
        .i_wr_idx  (r_item.button[IDX_W-1:0]),
        .i_wr_data (upd_entry)
    );

    bplar_upd u_upd (
        .i_item  (r_item),
        .i_entry (rd_entry),
        .i_cfg   (r_cfg),
        .o_entry (upd_entry),
        .o_res   (upd_res)
    );

    // sequencer, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (done) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item     <= i_in;
            r_in_range <= in_range;
        end
        if (done) begin
            // out-of-range button: no state change, all-zero result
            r_out <= r_in_range ? upd_res : '0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_delay_ms     <= RST_FIRST_DELAY;
            r_cfg.repeat_interval_ms <= RST_REPEAT_INTV;
            r_cfg.fast_interval_ms   <= RST_FAST_INTV;
            r_cfg.accel_after_ms     <= RST_ACCEL_AFTER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_DELAY: r_cfg.first_delay_ms     <= i_cfg_data;
                CFG_REPEAT_INTV: r_cfg.repeat_interval_ms <= i_cfg_data;
                CFG_FAST_INTV:   r_cfg.fast_interval_ms   <= i_cfg_data;
                CFG_ACCEL_AFTER: r_cfg.accel_after_ms     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== bench/repeat_latch_checker.sv =====
// Transaction monitor, predictor and scoreboard for the button repeat/latch core.
module repeat_latch_checker #(
    parameter int unsigned BUTTONS = 17
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  bplar_pkg::t_in              i_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  bplar_pkg::t_out             i_out,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [bplar_pkg::CFG_W-1:0] i_cfg_data,
    output int unsigned                 o_errors,
    output int unsigned                 o_outstanding,
    output int unsigned                 o_results,
    output int unsigned                 o_fires
);
    timeunit 1ns;
    timeprecision 1ps;

    import bplar_pkg::*;

    t_cfg             settings;
    logic             btn_down   [BUTTONS];
    logic             btn_latch  [BUTTONS];
    logic             btn_armed  [BUTTONS];
    logic [DL_W-1:0]  deadline   [BUTTONS];
    logic [NOW_W-1:0] hold_from  [BUTTONS];

    t_out        expected_responses[$];
    t_out        want;
    int unsigned mismatches = 0;
    int unsigned n_checked  = 0;
    int unsigned n_fired    = 0;

    assign o_errors  = mismatches;
    assign o_results = n_checked;
    assign o_fires   = n_fired;

    task automatic report_mismatch(input string msg);
        if (mismatches < 40) $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Apply one transaction to the button table, return the response it produces.
    function automatic t_out predict_response(input t_in item);
        t_out             r;
        int unsigned      b;
        logic [DL_W-1:0]  now32;
        longint           hold;
        r     = '0;
        b     = 32'(item.button);
        now32 = {1'b0, item.now_ms};
        if (b >= BUTTONS) return r;
        case (item.op)
            OP_EVENT: begin
                if (item.level && !btn_down[b]) btn_latch[b] = 1'b1;
                btn_down[b] = item.level;
            end
            OP_QUERY: begin
                if (!btn_down[b]) begin
                    btn_armed[b] = 1'b0;
                end else if (!btn_armed[b]) begin
                    hold_from[b] = item.now_ms;
                    deadline[b]  = now32 + DL_W'(settings.first_delay_ms);
                    btn_armed[b] = 1'b1;
                    btn_latch[b] = 1'b0;
                    r.fire       = 1'b1;
                end else if (now32 >= deadline[b]) begin
                    hold = longint'(now32) - longint'({1'b0, hold_from[b]});
                    if (hold > longint'(settings.accel_after_ms))
                        deadline[b] = now32 + DL_W'(settings.fast_interval_ms);
                    else
                        deadline[b] = now32 + DL_W'(settings.repeat_interval_ms);
                    r.fire = 1'b1;
                end
            end
            OP_TAKE: begin
                r.fire       = btn_latch[b];
                btn_latch[b] = 1'b0;
            end
            default: ;
        endcase
        r.held = btn_down[b];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settings.first_delay_ms     = RST_FIRST_DELAY;
            settings.repeat_interval_ms = RST_REPEAT_INTV;
            settings.fast_interval_ms   = RST_FAST_INTV;
            settings.accel_after_ms     = RST_ACCEL_AFTER;
            for (int i = 0; i < BUTTONS; i++) begin
                btn_down[i]  = 1'b0;
                btn_latch[i] = 1'b0;
                btn_armed[i] = 1'b0;
                deadline[i]  = '0;
                hold_from[i] = '0;
            end
            expected_responses.delete();
        end else begin
            // a response always trails its request
            if (i_out_valid && i_out_ready) begin
                if (expected_responses.size() == 0) begin
                    report_mismatch($sformatf("response %0d arrived with none expected",
                                              n_checked));
                end else begin
                    want = expected_responses.pop_front();
                    if (i_out.fire !== want.fire)
                        report_mismatch($sformatf("response %0d fire expected %0b got %0b",
                                                  n_checked, want.fire, i_out.fire));
                    if (i_out.held !== want.held)
                        report_mismatch($sformatf("response %0d held expected %0b got %0b",
                                                  n_checked, want.held, i_out.held));
                end
                if (i_out.fire === 1'b1) n_fired++;
                n_checked++;
            end
            if (i_in_valid && i_in_ready)
                expected_responses.push_back(predict_response(i_in));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIRST_DELAY: settings.first_delay_ms     = i_cfg_data;
                    CFG_REPEAT_INTV: settings.repeat_interval_ms = i_cfg_data;
                    CFG_FAST_INTV:   settings.fast_interval_ms   = i_cfg_data;
                    CFG_ACCEL_AFTER: settings.accel_after_ms     = i_cfg_data;
                    default: ;
                endcase
            end
        end
        // registered so the stimulus side sees a value settled at the last edge
        o_outstanding <= expected_responses.size();
    end

endmodule

// ===== bench/button_press_latch_auto_repeat_core_tb.sv =====
// Top of the testbench: clock, reset, stimulus, flow control and verdict.
module button_press_latch_auto_repeat_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bplar_pkg::*;

    localparam int unsigned N_BUTTONS   = 17;
    localparam int unsigned PHASE_ITEMS = 190;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PRESS_PHASE = 4;   // phase with the long output hold-off
    localparam int unsigned HOLD_CYCLES = 300;
    // op code three is not named in the package; the core must treat it as a no-op
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_in                in_bus   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out               out_bus;
    logic               cfg_we   = 1'b0;
    logic [1:0]         cfg_idx  = CFG_FIRST_DELAY;
    logic [CFG_W-1:0]   cfg_data = '0;

    // output hold-off request, raised by the pressure process only
    logic               hold_rx  = 1'b0;

    int unsigned        errors, outstanding, results, fires;

    // flow-control mix for the current phase
    int unsigned        tx_idle_pct  = 0;
    int unsigned        rx_stall_pct = 0;
    int                 phase_id     = -1;

    // stimulus bookkeeping
    int unsigned        items_sent   = 0;
    int unsigned        n_settings   = 1;
    logic [NOW_W-1:0]   clock_ms     = '0;
    int unsigned        cur_first    = 32'(RST_FIRST_DELAY);
    int unsigned        cur_rep      = 32'(RST_REPEAT_INTV);
    int unsigned        cur_accel    = 32'(RST_ACCEL_AFTER);

    always #10 clk = ~clk;

    button_press_latch_auto_repeat_core #(
        .BUTTONS (N_BUTTONS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_bus),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    repeat_latch_checker #(
        .BUTTONS (N_BUTTONS)
    ) scoreboard (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in          (in_bus),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out         (out_bus),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_results     (results),
        .o_fires       (fires)
    );

    // Receiver: random stalls per the phase mix, forced low during the hold-off.
    always @(posedge clk) begin
        out_ready <= !hold_rx && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Pressure: once the pressure phase starts, refuse responses for a long
    // stretch so the core's pipeline fills and drops in_ready while the
    // sender keeps a transaction on offer.
    initial begin
        wait (phase_id == PRESS_PHASE);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("button_press_latch_auto_repeat_core verification failed");
        $finish;
    end

    // Offer one transaction and return at the edge that accepts it. The
    // optional idle cycles come first, so valid is never dropped and raised
    // in the same time step.
    task automatic push_item(input logic [1:0] op, input logic [BTN_W-1:0] btn,
                             input logic lvl, input logic [NOW_W-1:0] now);
        t_in item;
        item.op     = op;
        item.button = btn;
        item.level  = lvl;
        item.now_ms = now;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_bus   <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (btn < N_BUTTONS) items_sent++;
    endtask

    // Stop offering, wait for every predicted response, then let the
    // pipeline settle before anything touches the registers.
    task automatic drain_core();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Program all four timing registers on consecutive edges, core idle.
    task automatic load_timing(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] rep,
                               input logic [CFG_W-1:0] fast, input logic [CFG_W-1:0] accel);
        drain_core();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FIRST_DELAY;
        cfg_data <= first;
        @(posedge clk);
        cfg_idx  <= CFG_REPEAT_INTV;
        cfg_data <= rep;
        @(posedge clk);
        cfg_idx  <= CFG_FAST_INTV;
        cfg_data <= fast;
        @(posedge clk);
        cfg_idx  <= CFG_ACCEL_AFTER;
        cfg_data <= accel;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_first = 32'(first);
        cur_rep   = 32'(rep);
        cur_accel = 32'(accel);
        n_settings++;
    endtask

    // Next query time. Half the time spans scaled to the current timing so that
    // repeats and acceleration both happen; sometimes tiny steps, sometimes
    // exactly one interval to land on a deadline.
    function automatic logic [NOW_W-1:0] later_ms(input logic [NOW_W-1:0] t);
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 9);
        span = (cur_first + cur_accel) / 4 + cur_rep;
        if (pick < 3)
            return t + NOW_W'($urandom_range(0, 3));
        else if (pick == 3)
            return t + NOW_W'(cur_rep);
        else if (pick == 4)
            return t + NOW_W'(cur_first);
        return t + NOW_W'($urandom_range(0, span));
    endfunction

    // Well-formed hold: press, a run of queries with time moving forward,
    // sprinkled with takes and re-presses, then usually a release, mostly with a query.
    task automatic hold_sequence();
        logic [BTN_W-1:0] b;
        int unsigned      n_q;
        b   = BTN_W'($urandom_range(0, N_BUTTONS - 1));
        n_q = $urandom_range(1, 12);
        push_item(OP_EVENT, b, 1'b1, clock_ms);
        repeat (n_q) begin
            clock_ms = later_ms(clock_ms);
            case ($urandom_range(0, 9))
                0:       push_item(OP_TAKE, b, 1'($urandom_range(0, 1)), clock_ms);
                1:       push_item(OP_EVENT, b, 1'b1, clock_ms);
                2: begin
                    // release and re-press between queries keeps the deadline
                    push_item(OP_EVENT, b, 1'b0, clock_ms);
                    push_item(OP_EVENT, b, 1'b1, clock_ms);
                end
                default: push_item(OP_QUERY, b, 1'($urandom_range(0, 1)), clock_ms);
            endcase
        end
        if ($urandom_range(0, 9) < 8) begin
            push_item(OP_EVENT, b, 1'b0, clock_ms);
            if ($urandom_range(0, 9) < 7)
                push_item(OP_QUERY, b, 1'($urandom_range(0, 1)), later_ms(clock_ms));
        end
        if ($urandom_range(0, 1) == 0)
            push_item(OP_TAKE, b, 1'($urandom_range(0, 1)), clock_ms);
    endtask

    // Noise: any op, any button index including out of range, any time.
    task automatic noise_item();
        logic [NOW_W-1:0] t;
        if ($urandom_range(0, 1) == 0)
            t = NOW_W'($urandom);
        else
            t = clock_ms - NOW_W'($urandom_range(0, 500));
        push_item(2'($urandom_range(0, 3)), BTN_W'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)), t);
    endtask

    initial begin
        int unsigned phase_end;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset timing 350/60/25/1000, no idling ----
        push_item(OP_TAKE,  5'd0, 1'b0, 31'd0);          // empty latch
        push_item(OP_QUERY, 5'd0, 1'b0, 31'd1000);       // query on a button that is up
        push_item(OP_EVENT, 5'd0, 1'b1, 31'd0);          // fresh press sets latch
        push_item(OP_EVENT, 5'd0, 1'b1, 31'd0);          // press while down: no new latch
        push_item(OP_TAKE,  5'd0, 1'b0, 31'd0);          // latch returned
        push_item(OP_TAKE,  5'd0, 1'b0, 31'd0);          // and cleared
        push_item(OP_EVENT, 5'd0, 1'b0, 31'd0);
        push_item(OP_EVENT, 5'd0, 1'b1, 31'd0);          // latch set again
        push_item(OP_QUERY, 5'd0, 1'b0, 31'd1000);       // first query of a hold fires
        push_item(OP_TAKE,  5'd0, 1'b0, 31'd0);          // first fire cleared the latch
        push_item(OP_QUERY, 5'd0, 1'b0, 31'd1349);       // one short of the deadline
        push_item(OP_QUERY, 5'd0, 1'b0, 31'd1350);       // exactly on the deadline
        push_item(OP_QUERY, 5'd0, 1'b0, 31'd2000);       // hold equal to accel: normal rate
        push_item(OP_QUERY, 5'd0, 1'b0, 31'd2060);       // hold past accel: fast rate
        push_item(OP_EVENT, 5'd0, 1'b0, 31'd0);          // release between queries
        push_item(OP_EVENT, 5'd0, 1'b1, 31'd0);          // re-press keeps old deadline
        push_item(OP_QUERY, 5'd0, 1'b0, 31'd2084);
        push_item(OP_QUERY, 5'd0, 1'b0, 31'd2085);
        push_item(OP_EVENT, 5'd0, 1'b0, 31'd0);
        push_item(OP_QUERY, 5'd0, 1'b1, 31'd2200);       // query finds it up: disarm
        push_item(OP_EVENT, 5'd16, 1'b1, 31'h7FFF_FFFF); // last valid button
        push_item(OP_QUERY, 5'd16, 1'b1, 31'h7FFF_FFFF); // deadline past 31 bits
        push_item(OP_QUERY, 5'd16, 1'b0, 31'h7FFF_FFFF);
        push_item(OP_QUERY, 5'd16, 1'b0, 31'd0);         // time going backwards
        push_item(OP_UNUSED, 5'd16, 1'b1, 31'h5555_5555);
        push_item(OP_EVENT, 5'd17, 1'b1, 31'd0);         // out of range buttons
        push_item(OP_TAKE,  5'd31, 1'b1, 31'h2AAA_AAAA);

        // ---- random phases: timing setting and flow-control mix per phase ----
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: load_timing(16'd1, 16'd1, 16'd1, 16'd0);
                2: load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: load_timing(CFG_W'($urandom_range(1, 400)), CFG_W'($urandom_range(1, 100)),
                               CFG_W'($urandom_range(1, 50)), CFG_W'($urandom_range(0, 2000)));
                4: load_timing(CFG_W'($urandom_range(1, 65535)),
                               CFG_W'($urandom_range(1, 65535)),
                               CFG_W'($urandom_range(1, 65535)),
                               CFG_W'($urandom_range(0, 65535)));
                5: load_timing(16'hFFFF, 16'd1, 16'hFFFF, 16'd0);
                default: ;   // phase 0 runs on the reset timing
            endcase
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            // start each phase somewhere new so the high time bits toggle
            clock_ms  = NOW_W'($urandom_range(0, 32'h7E00_0000));
            phase_end = items_sent + PHASE_ITEMS;
            phase_id  = p;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 80)
                    hold_sequence();
                else
                    repeat ($urandom_range(1, 4)) noise_item();
            end
        end

        drain_core();
        repeat (8) @(posedge clk);
        $display("Covered %0d responses (%0d with fire set) across %0d timing settings,",
                 results, fires, n_settings);
        $display("with idle and stall mixes on both channels and one long output hold-off.");
        if (errors == 0) begin
            $display("button_press_latch_auto_repeat_core verification clean");
        end else begin
            $display("button_press_latch_auto_repeat_core verification failed");
        end
        $finish;
    end

endmodule
